### sv/julia_escape_time_pixel_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Julia escape-time pixel core
// Shared clocked property forms with active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH
`define JULIA_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH

// same-cycle implication
`define JETP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JETP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/jetp_pkg.sv
// ----------------------------------------------------------------------------
// jetp_pkg
// Types, constants and helpers shared by the Julia escape-time pixel core.
// ----------------------------------------------------------------------------
package jetp_pkg;

    localparam int Q_W        = 32;   // Q8.24 value width
    localparam int FRAC_BITS  = 24;
    localparam int STEP_W     = 31;
    localparam int PIX_W      = 10;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_FULL  = 2 * Q_W;   // exact Q16.48 product
    localparam int SUM_W      = 43;        // widest pre-saturation sum
    localparam int DIFF_W     = Q_W + 1;
    localparam int MAG_W      = 27;        // |d| <= 4.0 in Q8.24
    localparam int SQ_W       = 2 * MAG_W;

    localparam int MAX_ITER_DEF   = 100;
    localparam int COORD_BITS_DEF = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_C_REAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP   = 3'd5;

    localparam logic signed [Q_W-1:0] C_REAL_RST   = -32'sd8707180;
    localparam logic signed [Q_W-1:0] C_IMAG_RST   = 32'sd11542724;
    localparam logic signed [Q_W-1:0] X_ORIGIN_RST = 32'sd8388608;
    localparam logic signed [Q_W-1:0] Y_ORIGIN_RST = 32'sd8388608;
    localparam logic [STEP_W-1:0]     STEP_RST     = '0;

    // 4.0 in Q8.24, and 16.0 in Q16.48
    localparam logic [DIFF_W-1:0] ESC_LIM = 33'd1 << (FRAC_BITS + 2);
    localparam logic [SQ_W:0]     ESC_SQ  = 55'd1 << (2 * FRAC_BITS + 4);

    localparam logic signed [SUM_W-1:0] Q_MAX = 43'sd2147483647;
    localparam logic signed [SUM_W-1:0] Q_MIN = -43'sd2147483648;

    typedef struct packed {
        logic load;   // form Z0 from the accepted pixel
        logic mul;    // products of Z and squares of the distance
        logic upd;    // Z = Z*Z + C, new distance terms
    } t_cmd;

    typedef struct packed {
        logic esc;    // last completed iteration left the radius
    } t_stat;

    function automatic logic signed [Q_W-1:0] jetp_sat(input logic signed [SUM_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > Q_MAX) begin
            r = Q_MAX[Q_W-1:0];
        end else if (v < Q_MIN) begin
            r = Q_MIN[Q_W-1:0];
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

### sv/julia_escape_time_pixel_core.sv
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_core
// Julia set escape-time evaluator for one pixel per input item.
// ----------------------------------------------------------------------------
// Input stream: one item per pixel, column and row index. Output stream: one
// item per pixel, iteration count and escape flag. Config port: write enable,
// register index and data; write only while no pixel is in flight.
// The start point is origin + index*step, saturated to Q8.24; Z = Z*Z + C is
// iterated until |Z - Z0| exceeds 4 or MAX_ITER iterations are done.
// Each iteration runs on one shared datapath as a multiply cycle
// (three 32x32 products of Z, two squares of the previous distance) and an
// update cycle (sum, saturate, distance, escape check of the prior step).
// Pixels are handled one at a time; the next item is taken in the cycle
// after the result moves to the output register. The output register frees
// the core while a result waits; a stalled receiver holds the next result
// until the register empties.
// Reset restores the configuration defaults and empties the pipeline.
// ----------------------------------------------------------------------------
`include "julia_escape_time_pixel_core_macros.svh"

module julia_escape_time_pixel_core
    import jetp_pkg::*;
#(
    parameter int MAX_ITER   = MAX_ITER_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [Q_W-1:0]       i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // pixel_x[9:0], pixel_y[19:10], zero
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata    // iter_count[7:0], escaped[8], zero
);

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [CNT_W-1:0] w_iter_count;
    logic             w_escaped;

    jetp_ctrl #(
        .MAX_ITER (MAX_ITER)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_iter_count (w_iter_count),
        .o_escaped    (w_escaped),
        .o_cmd        (w_cmd),
        .i_stat       (w_stat)
    );

    jetp_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pixel_x   (s_axis_tdata[PIX_W-1:0]),
        .i_pixel_y   (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

    assign m_axis_tdata = {7'b0, w_escaped, w_iter_count};

    // a result always reports between one and MAX_ITER iterations
    `JETP_ASSERT_NOW(a_count_range, i_clk, i_rst_n, m_axis_tvalid,
        (w_iter_count != '0) && (w_iter_count <= CNT_W'(MAX_ITER)), "iteration count out of range")
    // a pixel that never escaped ran the full budget
    `JETP_ASSERT_NOW(a_full_run, i_clk, i_rst_n, m_axis_tvalid && !w_escaped,
        w_iter_count == CNT_W'(MAX_ITER), "non-escaped pixel stopped early")
    // one pixel in flight: the core is busy right after an accept
    `JETP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "second item accepted while busy")

endmodule

### sv/jetp_dp.sv
// ----------------------------------------------------------------------------
// jetp_dp
// Datapath: configuration registers, start point, iteration and escape test.
// ----------------------------------------------------------------------------
module jetp_dp
    import jetp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [Q_W-1:0]       i_cfg_wdata,
    input  logic [PIX_W-1:0]     i_pixel_x,
    input  logic [PIX_W-1:0]     i_pixel_y,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat
);

    localparam int PX_W   = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
    localparam int PROD_W = PX_W + STEP_W;

    logic signed [Q_W-1:0] r_c_real, r_c_imag, r_x_origin, r_y_origin;
    logic [STEP_W-1:0]     r_x_step, r_y_step;

    logic signed [Q_W-1:0]       r_z0r, r_z0i, r_zr, r_zi;
    logic signed [PROD_FULL-1:0] r_prr, r_pii, r_pri;
    logic [MAG_W-1:0]            r_dr_mag, r_di_mag;
    logic [SQ_W-1:0]             r_dsq_r, r_dsq_i;
    logic                        r_big;

    logic [PROD_W-1:0]             w_xprod, w_yprod;
    logic signed [SUM_W-1:0]       w_x_sum, w_y_sum;
    logic signed [Q_W-1:0]         w_z0r, w_z0i;
    logic signed [PROD_FULL-1:0]   w_re_full;
    logic signed [PROD_FULL-FRAC_BITS-1:0]   w_re;
    logic signed [PROD_FULL-FRAC_BITS:0]     w_im;
    logic signed [SUM_W-1:0]       w_re_sum, w_im_sum;
    logic signed [Q_W-1:0]         w_zr_n, w_zi_n;
    logic signed [DIFF_W-1:0]      w_dr, w_di;
    logic [DIFF_W-1:0]             w_dr_mag, w_di_mag;
    logic [SQ_W:0]                 w_dsq;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_real   <= C_REAL_RST;
            r_c_imag   <= C_IMAG_RST;
            r_x_origin <= X_ORIGIN_RST;
            r_y_origin <= Y_ORIGIN_RST;
            r_x_step   <= STEP_RST;
            r_y_step   <= STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_C_REAL:   r_c_real   <= i_cfg_wdata;
                CFG_C_IMAG:   r_c_imag   <= i_cfg_wdata;
                CFG_X_ORIGIN: r_x_origin <= i_cfg_wdata;
                CFG_Y_ORIGIN: r_y_origin <= i_cfg_wdata;
                CFG_X_STEP:   r_x_step   <= i_cfg_wdata[STEP_W-1:0];
                CFG_Y_STEP:   r_y_step   <= i_cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // start point, saturated to Q8.24
    assign w_xprod = PROD_W'(i_pixel_x[PX_W-1:0]) * PROD_W'(r_x_step);
    assign w_yprod = PROD_W'(i_pixel_y[PX_W-1:0]) * PROD_W'(r_y_step);
    assign w_x_sum = SUM_W'(r_x_origin) + $signed(SUM_W'(w_xprod));
    assign w_y_sum = SUM_W'(r_y_origin) + $signed(SUM_W'(w_yprod));
    assign w_z0r   = jetp_sat(w_x_sum);
    assign w_z0i   = jetp_sat(w_y_sum);

    // Z*Z + C: arithmetic shift is floor; imaginary part carries the factor 2
    assign w_re_full = r_prr - r_pii;
    assign w_re      = w_re_full[PROD_FULL-1:FRAC_BITS];
    assign w_im      = r_pri[PROD_FULL-1:FRAC_BITS-1];
    assign w_re_sum  = SUM_W'(w_re) + SUM_W'(r_c_real);
    assign w_im_sum  = SUM_W'(w_im) + SUM_W'(r_c_imag);
    assign w_zr_n    = jetp_sat(w_re_sum);
    assign w_zi_n    = jetp_sat(w_im_sum);

    // distance from the start point
    assign w_dr     = DIFF_W'(w_zr_n) - DIFF_W'(r_z0r);
    assign w_di     = DIFF_W'(w_zi_n) - DIFF_W'(r_z0i);
    assign w_dr_mag = w_dr[DIFF_W-1] ? DIFF_W'(-w_dr) : DIFF_W'(w_dr);
    assign w_di_mag = w_di[DIFF_W-1] ? DIFF_W'(-w_di) : DIFF_W'(w_di);

    // squares are exact once both magnitudes are within 4.0
    assign w_dsq      = (SQ_W + 1)'(r_dsq_r) + (SQ_W + 1)'(r_dsq_i);
    assign o_stat.esc = r_big | (w_dsq > ESC_SQ);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_z0r <= w_z0r;
            r_z0i <= w_z0i;
            r_zr  <= w_z0r;
            r_zi  <= w_z0i;
        end
        if (i_cmd.mul) begin
            r_prr   <= PROD_FULL'(r_zr) * PROD_FULL'(r_zr);
            r_pii   <= PROD_FULL'(r_zi) * PROD_FULL'(r_zi);
            r_pri   <= PROD_FULL'(r_zr) * PROD_FULL'(r_zi);
            r_dsq_r <= SQ_W'(r_dr_mag) * SQ_W'(r_dr_mag);
            r_dsq_i <= SQ_W'(r_di_mag) * SQ_W'(r_di_mag);
        end
        if (i_cmd.upd) begin
            r_zr     <= w_zr_n;
            r_zi     <= w_zi_n;
            r_dr_mag <= w_dr_mag[MAG_W-1:0];
            r_di_mag <= w_di_mag[MAG_W-1:0];
            r_big    <= (w_dr_mag > ESC_LIM) | (w_di_mag > ESC_LIM);
        end
    end

endmodule

### sv/jetp_ctrl.sv
// ----------------------------------------------------------------------------
// jetp_ctrl
// Sequencer: item handshake, iteration count, result register.
// ----------------------------------------------------------------------------
module jetp_ctrl
    import jetp_pkg::*;
#(
    parameter int MAX_ITER = MAX_ITER_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [CNT_W-1:0] o_iter_count,
    output logic             o_escaped,
    output t_cmd             o_cmd,
    input  t_stat            i_stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_WAIT = 2'd3;

    localparam logic [CNT_W-1:0] LAST = CNT_W'(MAX_ITER);

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_out_count;
    logic             r_out_esc;
    logic             w_out_load;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        o_cmd      = '0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_count    = '0;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_UPD;
            end
            ST_UPD: begin
                // the escape status belongs to iteration r_count
                if (r_count != '0 && (i_stat.esc || r_count == LAST)) begin
                    n_state = ST_WAIT;
                end else begin
                    o_cmd.upd = 1'b1;
                    n_count   = r_count + CNT_W'(1);
                    n_state   = ST_MUL;
                end
            end
            ST_WAIT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign n_out_valid = w_out_load | (r_out_valid & ~i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_count <= r_count;
            r_out_esc   <= i_stat.esc;
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_iter_count = r_out_count;
    assign o_escaped    = r_out_esc;

endmodule
